/* sv/cid_pkg.sv */
`default_nettype none
package cid_pkg;

    // Fixed widths of the interface fields.
    localparam int SAMPLE_BITS = 16;
    localparam int DERIV_BITS  = 40;

    // Number of jobs held between the front and the back part.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } cid_in_t;

    typedef struct packed {
        logic signed [DERIV_BITS-1:0] derivative;
        logic                         last_result;
    } cid_out_t;

    // Per-job classification made by the front part.
    typedef struct packed {
        logic first;   // first full window of the run: also emit the left edge
        logic last;    // last sample of the run: also emit the two right edges
    } cid_flags_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cid_q_status_t;

endpackage
`default_nettype wire

/* sv/cubic_interp_derivative_stream.sv */
// Streaming derivative of a sampled signal by local cubic interpolation.
//
// Input channel: drive sample_item and raise push; a transfer takes place at
// a rising edge with push high and full low. A run of samples ends with the
// item whose last_sample bit is set. Runs of fewer than four samples give no
// results. The fourth sample of a run gives two results, each later sample
// one, and the last sample two more, so a sample can cause up to four.
// Result channel: while empty is low the oldest result is on result_item;
// it transfers at a rising edge with pop high and empty low. A stalled
// receiver holds the result steady; jobs pile up in a four-entry queue and
// full rises once it is full.
// Configuration: wr_en with wr_data selects the first (0) or the second (1)
// derivative; write it only while no result is pending.
// A sample's job is written into the queue, and the back part registers
// its results in the output register. Throughput: one sample per cycle
// while full is low; the back part produces one result per cycle while
// the receiver pops, so the queue absorbs a run's extra start and end results.
// Reset clears the window, the run state, the queue and the output valid flag,
// and selects the first derivative.
`default_nettype none
module cubic_interp_derivative_stream #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    output logic               full,
    input  cid_pkg::cid_in_t   sample_item,
    output logic               empty,
    input  wire                pop,
    output cid_pkg::cid_out_t  result_item,
    input  wire                wr_en,
    input  wire                wr_data
);
    import cid_pkg::*;

    localparam int AW = SAMPLE_WIDTH + 3;
    localparam int DW = 3 * AW + $bits(cid_flags_t);

    logic                 order_reg;
    logic                 accept;
    logic                 job_push, job_pop;
    logic signed [AW-1:0] f_a0, f_a1, f_a2;
    logic signed [AW-1:0] b_a0, b_a1, b_a2;
    cid_flags_t           f_flags, b_flags;
    logic [DW-1:0]        q_wdata, q_rdata;
    cid_q_status_t        q_status;

    // The user must change the order register only while the block is idle; the block itself does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            order_reg <= wr_data;
        end
    end

    assign full   = q_status.full;
    assign accept = push && !full;

    // Front: shift the window, track the run, and form the cubic's
    // coefficients for every sample that produces results.
    cid_front #(
        .SW(SAMPLE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .sample_item(sample_item),
        .job_push   (job_push),
        .job_a0     (f_a0),
        .job_a1     (f_a1),
        .job_a2     (f_a2),
        .job_flags  (f_flags)
    );

    assign q_wdata = {f_a0, f_a1, f_a2, f_flags};

    cid_queue #(
        .DW(DW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (q_wdata),
        .pop   (job_pop),
        .rdata (q_rdata),
        .status(q_status)
    );

    assign b_a0    = q_rdata[DW-1 -: AW];
    assign b_a1    = q_rdata[DW-1-AW -: AW];
    assign b_a2    = q_rdata[DW-1-2*AW -: AW];
    assign b_flags = q_rdata[$bits(cid_flags_t)-1:0];

    // Back: walk the evaluation points of each job, one result per cycle while the receiver does not stall.
    cid_back #(
        .SW(SAMPLE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .order      (order_reg),
        .job_valid  (!q_status.empty),
        .job_a0     (b_a0),
        .job_a1     (b_a1),
        .job_a2     (b_a2),
        .job_flags  (b_flags),
        .job_pop    (job_pop),
        .pop        (pop),
        .empty      (empty),
        .result_item(result_item)
    );

    // With the queue full and no result shown, a result is shown in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (full && empty) |=> !empty)
        else $error("queue full but no result presented");

    // With no job queued and no sample taken, no result can appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.empty && empty && !accept) |=> empty)
        else $error("result appeared without a queued job");

    // A job leaves the queue only while a result is being produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> !empty)
        else $error("job retired without a result");

endmodule
`default_nettype wire

/* sv/cid_front.sv */
`default_nettype none
module cid_front #(
    parameter int SW = 16
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     accept,
    input  cid_pkg::cid_in_t        sample_item,
    output logic                    job_push,
    output logic signed [SW+2:0]    job_a0,
    output logic signed [SW+2:0]    job_a1,
    output logic signed [SW+2:0]    job_a2,
    output cid_pkg::cid_flags_t     job_flags
);
    import cid_pkg::*;

    localparam int AW = SW + 3;

    logic signed [SW-1:0] window_reg [4];
    logic signed [SW-1:0] window_next [4];
    logic [1:0]           seen_reg, seen_next;
    logic                 full_win_reg, full_win_next;
    logic [SW+SAMPLE_BITS-1:0] raw_ext;
    logic signed [AW-1:0] y0, y1, y2, y3;

    // Keep the low SW bits of the sample, two's complement.
    assign raw_ext = {{SW{1'b0}}, sample_item.sample};

    always_comb
    begin
        window_next[0] = window_reg[1];
        window_next[1] = window_reg[2];
        window_next[2] = window_reg[3];
        window_next[3] = raw_ext[SW-1:0];

        y0 = {{3{window_next[0][SW-1]}}, window_next[0]};
        y1 = {{3{window_next[1][SW-1]}}, window_next[1]};
        y2 = {{3{window_next[2][SW-1]}}, window_next[2]};
        y3 = {{3{window_next[3][SW-1]}}, window_next[3]};

        job_a0 = y3 - y2 - y0 + y1;
        job_a1 = (y0 <<< 1) - (y1 <<< 1) + y2 - y3;
        job_a2 = y2 - y0;

        job_push        = accept && (full_win_reg || (seen_reg == 2'd3));
        job_flags.first = !full_win_reg;
        job_flags.last  = sample_item.last_sample;

        seen_next     = seen_reg;
        full_win_next = full_win_reg;
        if (accept)
        begin
            if (!full_win_reg)
            begin
                if (seen_reg != 2'd3)
                begin
                    seen_next = seen_reg + 2'd1;
                end
                else
                begin
                    full_win_next = 1'b1;
                end
            end
            if (sample_item.last_sample)
            begin
                seen_next     = 2'd0;
                full_win_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                window_reg[i] <= '0;
            end
            seen_reg     <= 2'd0;
            full_win_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    window_reg[i] <= window_next[i];
                end
            end
            seen_reg     <= seen_next;
            full_win_reg <= full_win_next;
        end
    end

endmodule
`default_nettype wire

/* sv/cid_queue.sv */
`default_nettype none
module cid_queue #(
    parameter int DW = 8
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push,
    input  wire  [DW-1:0]            wdata,
    input  wire                      pop,
    output logic [DW-1:0]            rdata,
    output cid_pkg::cid_q_status_t   status
);
    import cid_pkg::*;

    localparam int PTRW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [DW-1:0]   mem [QUEUE_DEPTH];
    logic [PTRW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic            do_push, do_pop;

    assign status.full  = (count_reg == CNTW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* sv/cid_back.sv */
`default_nettype none
module cid_back #(
    parameter int SW = 16
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     order,
    input  wire                     job_valid,
    input  wire signed [SW+2:0]     job_a0,
    input  wire signed [SW+2:0]     job_a1,
    input  wire signed [SW+2:0]     job_a2,
    input  cid_pkg::cid_flags_t     job_flags,
    output logic                    job_pop,
    input  wire                     pop,
    output logic                    empty,
    output cid_pkg::cid_out_t       result_item
);
    import cid_pkg::*;

    localparam int AW = SW + 3;
    localparam int PW = SW + 8;
    localparam int RW = (SW + 25 > DERIV_BITS + 1) ? SW + 25 : DERIV_BITS + 1;

    // Evaluation point of the cubic within the window.
    typedef enum logic [1:0] {
        POS_M_NEG1,
        POS_M_ZERO,
        POS_M_ONE,
        POS_M_TWO
    } pos_t;

    logic [1:0]           step_reg;
    logic [1:0]           last_step;
    logic                 step_done;
    logic                 load;
    pos_t                 pos;
    logic signed [PW-1:0] a0e, a1e, a2e, p, s7;
    logic signed [RW-1:0] r, hi, lo;
    logic [DERIV_BITS-1:0] sat;
    cid_out_t             result_reg;
    logic                 valid_reg;

    always_comb
    begin
        unique case ({job_flags.first, job_flags.last})
            2'b11:   last_step = 2'd3;
            2'b10:   last_step = 2'd1;
            2'b01:   last_step = 2'd2;
            default: last_step = 2'd0;
        endcase
        step_done = (step_reg == last_step);
        load      = job_valid && (!valid_reg || pop);
        job_pop   = load && step_done;

        pos = pos_t'(step_reg + {1'b0, !job_flags.first});
        // In second-order mode the final result repeats the one before it.
        if (order && (pos == POS_M_TWO))
        begin
            pos = POS_M_ONE;
        end

        a0e = {{(PW-AW){job_a0[AW-1]}}, job_a0};
        a1e = {{(PW-AW){job_a1[AW-1]}}, job_a1};
        a2e = {{(PW-AW){job_a2[AW-1]}}, job_a2};
        s7  = (a0e <<< 3) - a0e;

        if (!order)
        begin
            unique case (pos)
                POS_M_NEG1: p = a2e + (a0e <<< 1) + a0e - (a1e <<< 1);
                POS_M_ZERO: p = a2e;
                POS_M_ONE:  p = a2e + (a0e <<< 1) + a0e + (a1e <<< 1);
                POS_M_TWO:  p = a2e + (a0e <<< 3) + (a0e <<< 2) + (a1e <<< 2);
                default:    p = a2e;
            endcase
        end
        else
        begin
            unique case (pos)
                POS_M_NEG1: p = (a1e <<< 1) - (a0e <<< 2) - (a0e <<< 1);
                POS_M_ZERO: p = (a1e <<< 1);
                default:    p = (a1e <<< 1) + (a0e <<< 2) + (a0e <<< 1);
            endcase
        end

        r = {{(RW-PW-16){p[PW-1]}}, p, 16'b0};
        if (!order)
        begin
            r = r + {{(RW-PW){s7[PW-1]}}, s7};
        end

        hi = {{(RW-DERIV_BITS+1){1'b0}}, {(DERIV_BITS-1){1'b1}}};
        lo = ~hi;
        priority if (r > hi)
        begin
            sat = hi[DERIV_BITS-1:0];
        end
        else if (r < lo)
        begin
            sat = lo[DERIV_BITS-1:0];
        end
        else
        begin
            sat = r[DERIV_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.derivative  <= sat;
            result_reg.last_result <= job_flags.last && step_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg  <= step_done ? 2'd0 : step_reg + 2'd1;
                valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign empty       = !valid_reg;
    assign result_item = result_reg;

endmodule
`default_nettype wire

/* dv/cid_tb_pkg.sv */
package cid_tb_pkg;

    // Values of the one configuration register.
    typedef enum logic {
        ORDER_FIRST  = 1'b0,
        ORDER_SECOND = 1'b1
    } deriv_order_e;

endpackage

/* dv/cid_checker.sv */
module cid_checker
    import cid_pkg::*;
    import cid_tb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  logic     full,
    input  cid_in_t  sample_item,
    input  logic     empty,
    input  logic     pop,
    input  cid_out_t result_item,
    input  logic     wr_en,
    input  logic     wr_data,
    output int       fail_count,
    output int       pending,
    output int       checked
);

    localparam longint Q_ONE   = 65536;
    localparam longint H2_TERM = 7;

    logic signed [SAMPLE_BITS-1:0] win [4];
    logic [1:0]                    seen;
    logic                          win_full;
    deriv_order_e                  order_q;
    cid_out_t                      deriv_q [$];
    int                            errs;
    int                            n_checked;

    // Derivative of the cubic through the current window at position m.
    function automatic logic signed [DERIV_BITS-1:0] deriv_at(input longint m);
        longint y0, y1, y2, y3, a0, a1, a2, r, hi, lo;
        y0 = win[0];
        y1 = win[1];
        y2 = win[2];
        y3 = win[3];
        a0 = y3 - y2 - y0 + y1;
        a1 = 2 * y0 - 2 * y1 + y2 - y3;
        a2 = y2 - y0;
        if (order_q == ORDER_FIRST)
            r = a2 * Q_ONE + a0 * (3 * m * m * Q_ONE + H2_TERM) + 2 * m * a1 * Q_ONE;
        else
            r = (6 * m * a0 + 2 * a1) * Q_ONE;
        hi = (longint'(1) <<< (DERIV_BITS - 1)) - 1;
        lo = -hi - 1;
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        return r[DERIV_BITS-1:0];
    endfunction

    task automatic add_deriv(input logic signed [DERIV_BITS-1:0] v, input logic lst);
        cid_out_t e;
        e.derivative  = v;
        e.last_result = lst;
        deriv_q.push_back(e);
    endtask

    task automatic predict(input cid_in_t it);
        logic signed [DERIV_BITS-1:0] tail;
        win[0] = win[1];
        win[1] = win[2];
        win[2] = win[3];
        win[3] = it.sample;
        if (!win_full)
        begin
            if (seen < 3)
            begin
                seen++;
                if (it.last_sample)
                    seen = '0;
                return;
            end
            win_full = 1'b1;
            add_deriv(deriv_at(-1), 1'b0);
        end
        add_deriv(deriv_at(0), 1'b0);
        if (it.last_sample)
        begin
            // In second-order mode the final result repeats the one before it.
            tail = deriv_at(1);
            add_deriv(tail, 1'b0);
            if (order_q == ORDER_FIRST)
                tail = deriv_at(2);
            add_deriv(tail, 1'b1);
            seen     = '0;
            win_full = 1'b0;
        end
    endtask

    task automatic check_result(input cid_out_t got);
        cid_out_t want;
        if (deriv_q.size() == 0)
        begin
            if (errs < 10)
                $display("Result %0d arrived with nothing expected: derivative %0d last %0b",
                         n_checked, got.derivative, got.last_result);
            errs++;
            return;
        end
        want = deriv_q.pop_front();
        if (got.derivative !== want.derivative || got.last_result !== want.last_result)
        begin
            if (errs < 10)
                $display("Result %0d wrong: expected derivative %0d last %0b, got %0d last %0b",
                         n_checked, want.derivative, want.last_result,
                         got.derivative, got.last_result);
            errs++;
        end
        n_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                win[i] = '0;
            seen      = '0;
            win_full  = 1'b0;
            order_q   = ORDER_FIRST;
            deriv_q.delete();
            errs      = 0;
            n_checked = 0;
            pending    <= 0;
            fail_count <= 0;
            checked    <= 0;
        end
        else
        begin
            // Results leave before this edge's sample can add any, and a register
            // write only affects samples after this edge.
            if (pop && !empty)
                check_result(result_item);
            if (push && !full)
                predict(sample_item);
            if (wr_en)
                order_q = deriv_order_e'(wr_data);
            pending    <= deriv_q.size();
            fail_count <= errs;
            checked    <= n_checked;
        end
    end

endmodule

/* dv/tb.sv */
module tb;
    import cid_pkg::*;
    import cid_tb_pkg::*;

    // Far above the slowest correct run: about 350 samples, each with the
    // longest idle gap and up to four results, each stalled for the longest burst.
    localparam int CYCLE_LIMIT = 200000;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    cid_in_t  sample_item;
    logic     empty;
    logic     pop = 1'b0;
    cid_out_t result_item;
    logic     wr_en;
    logic     wr_data;

    int fail_count;
    int pending;
    int checked;

    // Pacing of both sides. calm switches all idling off for the last phase.
    int   tx_pct;
    int   rx_pct;
    logic calm;
    int   stall_left;

    // Bookkeeping for the closing summary.
    int items_sent;
    int runs_sent;
    int short_runs;
    int run_len;
    int order_writes;
    int cycles;

    cubic_interp_derivative_stream u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample_item (sample_item),
        .empty       (empty),
        .pop         (pop),
        .result_item (result_item),
        .wr_en       (wr_en),
        .wr_data     (wr_data)
    );

    cid_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample_item (sample_item),
        .empty       (empty),
        .pop         (pop),
        .result_item (result_item),
        .wr_en       (wr_en),
        .wr_data     (wr_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hang anywhere in the block ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Cycle limit reached with %0d results still outstanding.", pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: pop stays high except during random stall bursts, so stalls
    // can land on any result of a run's output.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < rx_pct)
        begin
            stall_left = $urandom_range(1, 8) - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    task automatic pick_pace();
        tx_pct = pick_pct();
        rx_pct = pick_pct();
    endtask

    // One sample transfer. An optional idle burst comes first; push is left
    // high on return so that back-to-back samples follow without a gap.
    task automatic send(input logic signed [SAMPLE_BITS-1:0] s, input logic lst);
        int gap;
        if (!calm && $urandom_range(0, 99) < tx_pct)
        begin
            gap = $urandom_range(1, 8);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        sample_item <= '{sample: s, last_sample: lst};
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        run_len++;
        if (lst)
        begin
            runs_sent++;
            if (run_len < 4)
                short_runs++;
            run_len = 0;
        end
    endtask

    // Stops the sender until every predicted result has been taken, then
    // lets the pipeline settle. The first edge makes sure the checker has
    // seen the last transfer before its pending count is trusted.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_order(input deriv_order_e v);
        drain();
        wr_en   <= 1'b1;
        wr_data <= v;
        @(posedge clk);
        wr_en <= 1'b0;
        order_writes++;
    endtask

    // Sample styles: full range, the extremes with zero and minus one, a narrow
    // band near zero, and a random walk that looks like a real signal.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
        input int style, input logic signed [SAMPLE_BITS-1:0] prev);
        case (style)
            0: return SAMPLE_BITS'($urandom);
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            2: return SAMPLE_BITS'($signed($urandom_range(0, 64)) - 32);
            default: return SAMPLE_BITS'(prev + $signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // Most runs are long enough to produce results; some are short or long.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return $urandom_range(1, 3);
        else if (r < 25)
            return $urandom_range(11, 30);
        else if (r < 30)
            return 4;
        else
            return $urandom_range(5, 10);
    endfunction

    task automatic send_run(input int len, input int style);
        logic signed [SAMPLE_BITS-1:0] s;
        s = SAMPLE_BITS'($urandom);
        for (int k = 0; k < len; k++)
        begin
            s = pick_sample(style, s);
            send(s, k == len - 1);
        end
    endtask

    initial
    begin
        int start;
        rst_n       = 1'b0;
        push        = 1'b0;
        sample_item = '0;
        wr_en       = 1'b0;
        wr_data     = 1'b0;
        calm        = 1'b0;
        tx_pct      = 0;
        rx_pct      = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first derivative after reset. A four-sample run of
        // alternating extremes gives all four results from its last sample.
        send(16'sh7FFF, 1'b0);
        send(16'sh8000, 1'b0);
        send(16'sh7FFF, 1'b0);
        send(16'sh8000, 1'b1);
        // Runs of one, two and three samples give nothing.
        send(16'sh0000, 1'b1);
        send(16'shFFFF, 1'b0);
        send(16'sh7FFF, 1'b1);
        send(16'sh8000, 1'b0);
        send(16'sh8000, 1'b0);
        send(16'sh8000, 1'b1);
        // A five-sample run gives two results from its fourth sample and three from its last.
        send(16'sh8000, 1'b0);
        send(16'sh7FFF, 1'b0);
        send(16'sh8000, 1'b0);
        send(16'sh7FFF, 1'b0);
        send(16'shFFFF, 1'b1);

        // Second derivative: the last result repeats the one before it.
        set_order(ORDER_SECOND);
        send(16'sh7FFF, 1'b0);
        send(16'sh8000, 1'b0);
        send(16'sh8000, 1'b0);
        send(16'sh7FFF, 1'b1);

        // Change of order in the middle of a run, once its results are out.
        send(16'sh0001, 1'b0);
        send(16'sh0002, 1'b0);
        send(-16'sd3, 1'b0);
        send(16'sh0064, 1'b0);
        set_order(ORDER_FIRST);
        send(16'sh8000, 1'b0);
        send(16'sh7FFF, 1'b1);

        // Random phases, each with its own order setting and pacing. The
        // first two force both register values; the last one runs flat out.
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph == 0)
                set_order(ORDER_SECOND);
            else if (ph == 1)
                set_order(ORDER_FIRST);
            else
                set_order(deriv_order_e'($urandom_range(0, 1)));
            calm = (ph == 6);
            pick_pace();
            start = items_sent;
            while (items_sent - start < 40)
            begin
                if ($urandom_range(0, 11) == 0)
                    pick_pace();
                if ($urandom_range(0, 14) == 0)
                    drain();
                send_run(pick_len(), $urandom_range(0, 3));
            end
        end

        drain();
        repeat (8) @(posedge clk);

        $display("Sent %0d samples in %0d runs (%0d too short to give a result), %0d order writes;",
                 items_sent, runs_sent, short_runs, order_writes);
        $display("checked %0d derivative results against the prediction.", checked);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
sv/cid_pkg.sv
sv/cid_front.sv
sv/cid_queue.sv
sv/cid_back.sv
sv/cubic_interp_derivative_stream.sv
dv/cid_tb_pkg.sv
dv/cid_checker.sv
dv/tb.sv
